// File: design/hrv_time_domain_stats_defines.svh
// Assertion macros for the HRV time-domain statistics block.
// Used by the checker; expects clk_i and rst_ni in the scope of use.
`ifndef HRV_TIME_DOMAIN_STATS_DEFINES_SVH
`define HRV_TIME_DOMAIN_STATS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HRV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/hrv_tds_pkg.sv
// Shared constants, command and status types for the HRV statistics block.
// No dependencies; used by the controller, the datapath and the top level.
package hrv_tds_pkg;

  localparam int unsigned MAX_INTERVALS_DEF  = 65535;
  localparam int unsigned INTERVAL_WIDTH_DEF = 16;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned SQ_W    = 48;
  localparam int unsigned THR_W   = 10;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned PNN_W   = 15;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [THR_W-1:0]  THR_RESET = 10'd18;
  localparam logic [ADDR_W-1:0] ADDR_THR  = 3'd0;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_SD   = 2'd1,
    DIV_RM   = 2'd2,
    DIV_PN   = 2'd3
  } div_src_e;

  typedef enum logic [2:0] {
    MUL_N_QLO = 3'd0,
    MUL_N_QHI = 3'd1,
    MUL_S_S   = 3'd2,
    MUL_N_NM1 = 3'd3,
    MUL_NN_K  = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_LOAD   = 2'd1,
    ACC_ADD_HI = 2'd2,
    ACC_SUB    = 2'd3
  } acc_op_e;

  typedef struct packed {
    logic     capture;
    logic     step_iv;
    logic     step_acc;
    acc_op_e  acc_op;
    mul_sel_e mul_sel;
    logic     div_start;
    div_src_e div_src;
    logic     sqrt_start;
    logic     wr_mean;
    logic     wr_sdnn;
    logic     zero_sdnn;
    logic     wr_rmssd;
    logic     wr_pnn;
    logic     out_load;
    logic     clear;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic too_few;
    logic neg;
    logic div_busy;
    logic sqrt_busy;
  } status_t;

endpackage

// File: design/hrv_tds_ctrl.sv
// Sequencing state machine of the HRV statistics block.
// Depends on hrv_tds_pkg; drives the datapath through cmd_t.
module hrv_tds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  hrv_tds_pkg::status_t status_i,
  output hrv_tds_pkg::cmd_t    cmd_o
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_IV      = 16'h0002,
    S_ACC     = 16'h0004,
    S_CHECK   = 16'h0008,
    S_MEAN    = 16'h0010,
    S_MUL_HI  = 16'h0020,
    S_MUL_SS  = 16'h0040,
    S_MUL_NN  = 16'h0080,
    S_SD_LOAD = 16'h0100,
    S_SD_DIV  = 16'h0200,
    S_SD_SQ   = 16'h0400,
    S_RM_DIV  = 16'h0800,
    S_RM_SQ   = 16'h1000,
    S_PN_LOAD = 16'h2000,
    S_PN_DIV  = 16'h4000,
    S_OUT     = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_IV;
        end
      end
      S_IV: begin
        cmd_o.step_iv = 1'b1;
        state_d       = S_ACC;
      end
      S_ACC: begin
        cmd_o.step_acc = 1'b1;
        state_d        = status_i.last ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (status_i.too_few) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = hrv_tds_pkg::DIV_MEAN;
          state_d         = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.mul_sel = hrv_tds_pkg::MUL_N_QLO;
        if (!status_i.div_busy) begin
          cmd_o.wr_mean = 1'b1;
          state_d       = S_MUL_HI;
        end
      end
      S_MUL_HI: begin
        cmd_o.acc_op  = hrv_tds_pkg::ACC_LOAD;
        cmd_o.mul_sel = hrv_tds_pkg::MUL_N_QHI;
        state_d       = S_MUL_SS;
      end
      S_MUL_SS: begin
        cmd_o.acc_op  = hrv_tds_pkg::ACC_ADD_HI;
        cmd_o.mul_sel = hrv_tds_pkg::MUL_S_S;
        state_d       = S_MUL_NN;
      end
      S_MUL_NN: begin
        cmd_o.acc_op  = hrv_tds_pkg::ACC_SUB;
        cmd_o.mul_sel = hrv_tds_pkg::MUL_N_NM1;
        state_d       = S_SD_LOAD;
      end
      S_SD_LOAD: begin
        // A negative variance from saturated sums leaves SDNN at zero.
        cmd_o.zero_sdnn = 1'b1;
        cmd_o.div_start = 1'b1;
        if (status_i.neg) begin
          cmd_o.div_src = hrv_tds_pkg::DIV_RM;
          state_d       = S_RM_DIV;
        end else begin
          cmd_o.div_src = hrv_tds_pkg::DIV_SD;
          state_d       = S_SD_DIV;
        end
      end
      S_SD_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_SD_SQ;
        end
      end
      S_SD_SQ: begin
        if (!status_i.sqrt_busy) begin
          cmd_o.wr_sdnn   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = hrv_tds_pkg::DIV_RM;
          state_d         = S_RM_DIV;
        end
      end
      S_RM_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.sqrt_start = 1'b1;
          state_d          = S_RM_SQ;
        end
      end
      S_RM_SQ: begin
        cmd_o.mul_sel = hrv_tds_pkg::MUL_NN_K;
        if (!status_i.sqrt_busy) begin
          cmd_o.wr_rmssd = 1'b1;
          state_d        = S_PN_LOAD;
        end
      end
      S_PN_LOAD: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_src   = hrv_tds_pkg::DIV_PN;
        state_d         = S_PN_DIV;
      end
      S_PN_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.wr_pnn = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: design/hrv_tds_dp.sv
// Datapath of the HRV statistics block: accumulators, shared multiplier,
// serial divider, serial square root and result registers. Uses hrv_tds_pkg.
module hrv_tds_dp #(
  parameter int unsigned MAX_INTERVALS  = hrv_tds_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned INTERVAL_WIDTH = hrv_tds_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [hrv_tds_pkg::THR_W-1:0]       thr_i,
  input  logic [31:0]                         peak_position_i,
  input  logic                                last_i,
  input  hrv_tds_pkg::cmd_t                   cmd_i,
  output hrv_tds_pkg::status_t                status_o,
  output logic [hrv_tds_pkg::OUT_W-1:0]       mean_rr_o,
  output logic [hrv_tds_pkg::OUT_W-1:0]       sdnn_o,
  output logic [hrv_tds_pkg::OUT_W-1:0]       rmssd_o,
  output logic [hrv_tds_pkg::COUNT_W-1:0]     nn50_count_o,
  output logic [hrv_tds_pkg::PNN_W-1:0]       pnn50_percent_o,
  output logic [hrv_tds_pkg::COUNT_W-1:0]     interval_count_o,
  output logic                                too_few_o
);

  localparam int unsigned IW       = INTERVAL_WIDTH;
  localparam int unsigned PW       = 2 * IW;
  localparam int unsigned CW       = hrv_tds_pkg::COUNT_W;
  localparam int unsigned SW       = hrv_tds_pkg::SUM_W;
  localparam int unsigned QW       = hrv_tds_pkg::SQ_W;
  localparam int unsigned OW       = hrv_tds_pkg::OUT_W;
  localparam int unsigned NUM_W    = 80;
  localparam int unsigned DEN_W    = 32;
  localparam int unsigned DCNT_W   = $clog2(NUM_W);
  localparam int unsigned RW       = 64;
  localparam int unsigned SQ_STEPS = RW / 2;
  localparam int unsigned SCNT_W   = $clog2(SQ_STEPS);
  localparam logic [31:0] PNN_SCALE = 32'd25600;
  localparam logic [RW-1:0] PNN_MAX = RW'(16'h7FFF);

  function automatic logic [OW-1:0] sat_out(input logic [RW-1:0] x);
    logic [OW-1:0] r;
    if (|x[RW-1:OW]) begin
      r = '1;
    end else begin
      r = x[OW-1:0];
    end
    return r;
  endfunction

  // Input capture and per-record state.
  logic [31:0]   peak_q;
  logic          last_q;
  logic [31:0]   prev_peak_q;
  logic          have_peak_q;
  logic [IW-1:0] prev_iv_q;
  logic          have_iv_q;
  logic [CW-1:0] total_q;
  logic [SW-1:0] sum_q;
  logic [QW-1:0] sq_q;
  logic [QW-1:0] dsq_q;
  logic [CW-1:0] nn_q;

  logic [IW-1:0] iv_q, d_q;
  logic          take_q, diff_q;

  logic [31:0]   raw_c;
  logic [IW-1:0] iv_c, d_c;
  logic          take_c;

  assign raw_c = peak_q - prev_peak_q;

  always_comb begin
    if (peak_q < prev_peak_q) begin
      iv_c = '0;
    end else if (|raw_c[31:IW]) begin
      iv_c = '1;
    end else begin
      iv_c = raw_c[IW-1:0];
    end
    d_c    = (iv_c >= prev_iv_q) ? (iv_c - prev_iv_q) : (prev_iv_q - iv_c);
    take_c = have_peak_q && (32'(total_q) < 32'(MAX_INTERVALS));
  end

  logic [PW-1:0] ivsq_c, dsq_c;
  logic [SW:0]   sum_add_c;
  logic [QW:0]   sq_add_c, dsq_add_c;

  assign ivsq_c    = PW'(iv_q) * PW'(iv_q);
  assign dsq_c     = PW'(d_q) * PW'(d_q);
  assign sum_add_c = {1'b0, sum_q} + (SW + 1)'(iv_q);
  assign sq_add_c  = {1'b0, sq_q} + (QW + 1)'(ivsq_c);
  assign dsq_add_c = {1'b0, dsq_q} + (QW + 1)'(dsq_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      peak_q <= peak_position_i;
      last_q <= last_i;
    end
    if (cmd_i.step_iv) begin
      iv_q   <= iv_c;
      d_q    <= d_c;
      take_q <= take_c;
      diff_q <= have_iv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_peak_q <= '0;
      have_peak_q <= 1'b0;
      prev_iv_q   <= '0;
      have_iv_q   <= 1'b0;
      total_q     <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      dsq_q       <= '0;
      nn_q        <= '0;
    end else if (cmd_i.clear) begin
      prev_peak_q <= '0;
      have_peak_q <= 1'b0;
      prev_iv_q   <= '0;
      have_iv_q   <= 1'b0;
      total_q     <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      dsq_q       <= '0;
      nn_q        <= '0;
    end else if (cmd_i.step_iv) begin
      prev_peak_q <= peak_q;
      have_peak_q <= 1'b1;
    end else if (cmd_i.step_acc && take_q) begin
      total_q   <= total_q + 1'b1;
      sum_q     <= sum_add_c[SW] ? '1 : sum_add_c[SW-1:0];
      sq_q      <= sq_add_c[QW] ? '1 : sq_add_c[QW-1:0];
      prev_iv_q <= iv_q;
      have_iv_q <= 1'b1;
      if (diff_q) begin
        dsq_q <= dsq_add_c[QW] ? '1 : dsq_add_c[QW-1:0];
        if ((32'(d_q) > 32'(thr_i)) && (nn_q != '1)) begin
          nn_q <= nn_q + 1'b1;
        end
      end
    end
  end

  // Shared multiplier with a registered product.
  logic [CW-1:0] nm1_c;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   p_q, acc_q;
  logic          neg_q;

  assign nm1_c = total_q - 1'b1;

  always_comb begin
    unique case (cmd_i.mul_sel)
      hrv_tds_pkg::MUL_N_QLO: begin
        mul_a = 32'(total_q);
        mul_b = sq_q[31:0];
      end
      hrv_tds_pkg::MUL_N_QHI: begin
        mul_a = 32'(total_q);
        mul_b = 32'(sq_q[QW-1:32]);
      end
      hrv_tds_pkg::MUL_S_S: begin
        mul_a = sum_q;
        mul_b = sum_q;
      end
      hrv_tds_pkg::MUL_N_NM1: begin
        mul_a = 32'(total_q);
        mul_b = 32'(nm1_c);
      end
      hrv_tds_pkg::MUL_NN_K: begin
        mul_a = 32'(nn_q);
        mul_b = PNN_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= 64'(mul_a) * 64'(mul_b);
    unique case (cmd_i.acc_op)
      hrv_tds_pkg::ACC_HOLD:   acc_q <= acc_q;
      hrv_tds_pkg::ACC_LOAD:   acc_q <= p_q;
      hrv_tds_pkg::ACC_ADD_HI: acc_q <= acc_q + {p_q[31:0], 32'd0};
      hrv_tds_pkg::ACC_SUB: begin
        acc_q <= acc_q - p_q;
        neg_q <= (acc_q < p_q);
      end
      default: acc_q <= acc_q;
    endcase
  end

  // Restoring divider, one quotient bit a cycle; the quotient shifts into num_q.
  logic [NUM_W-1:0]  num_q, num_load;
  logic [DEN_W-1:0]  den_q, den_load;
  logic [DEN_W-1:0]  rem_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic              div_busy_q;
  logic [DEN_W:0]    rem_sh_c;
  logic              q_bit_c;
  logic [RW-1:0]     quot_c;

  always_comb begin
    unique case (cmd_i.div_src)
      hrv_tds_pkg::DIV_MEAN: begin
        num_load = NUM_W'({sum_q, 8'd0}) + NUM_W'(total_q >> 1);
        den_load = DEN_W'(total_q);
      end
      hrv_tds_pkg::DIV_SD: begin
        num_load = NUM_W'({acc_q, 16'd0});
        den_load = p_q[DEN_W-1:0];
      end
      hrv_tds_pkg::DIV_RM: begin
        num_load = NUM_W'({dsq_q, 16'd0});
        den_load = DEN_W'(nm1_c);
      end
      hrv_tds_pkg::DIV_PN: begin
        num_load = NUM_W'(p_q) + NUM_W'(nm1_c >> 1);
        den_load = DEN_W'(nm1_c);
      end
      default: begin
        num_load = '0;
        den_load = '0;
      end
    endcase
  end

  assign rem_sh_c = {rem_q, num_q[NUM_W-1]};
  assign q_bit_c  = (rem_sh_c >= {1'b0, den_q});
  assign quot_c   = (|num_q[NUM_W-1:RW]) ? '1 : num_q[RW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      num_q     <= num_load;
      den_q     <= den_load;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (div_busy_q) begin
      num_q     <= {num_q[NUM_W-2:0], q_bit_c};
      rem_q     <= q_bit_c ? DEN_W'(rem_sh_c - {1'b0, den_q}) : rem_sh_c[DEN_W-1:0];
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
    end else if (div_busy_q && (div_cnt_q == DCNT_W'(NUM_W - 1))) begin
      div_busy_q <= 1'b0;
    end
  end

  // Digit-by-digit square root, two radicand bits a cycle.
  logic [RW-1:0]     v_q, r_q, bit_q;
  logic [SCNT_W-1:0] sq_cnt_q;
  logic              sqrt_busy_q;
  logic [RW-1:0]     t_c;
  logic [OW-1:0]     root_c;

  assign t_c    = r_q + bit_q;
  assign root_c = sat_out(r_q + RW'(v_q > r_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      v_q      <= quot_c;
      r_q      <= '0;
      bit_q    <= RW'(1) << (RW - 2);
      sq_cnt_q <= '0;
    end else if (sqrt_busy_q) begin
      if (v_q >= t_c) begin
        v_q <= v_q - t_c;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q    <= bit_q >> 2;
      sq_cnt_q <= sq_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqrt_busy_q <= 1'b0;
    end else if (cmd_i.sqrt_start) begin
      sqrt_busy_q <= 1'b1;
    end else if (sqrt_busy_q && (sq_cnt_q == SCNT_W'(SQ_STEPS - 1))) begin
      sqrt_busy_q <= 1'b0;
    end
  end

  // Result registers and the output register.
  logic [OW-1:0]                 mean_r, sdnn_r, rmssd_r;
  logic [hrv_tds_pkg::PNN_W-1:0] pnn_r;
  logic                          too_few_c;

  assign too_few_c = (total_q < CW'(2));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_mean) begin
      mean_r <= sat_out(quot_c);
    end
    if (cmd_i.zero_sdnn) begin
      sdnn_r <= '0;
    end else if (cmd_i.wr_sdnn) begin
      sdnn_r <= root_c;
    end
    if (cmd_i.wr_rmssd) begin
      rmssd_r <= root_c;
    end
    if (cmd_i.wr_pnn) begin
      pnn_r <= (quot_c > PNN_MAX) ? '1 : quot_c[hrv_tds_pkg::PNN_W-1:0];
    end
    if (cmd_i.out_load) begin
      too_few_o <= too_few_c;
      if (too_few_c) begin
        mean_rr_o        <= '0;
        sdnn_o           <= '0;
        rmssd_o          <= '0;
        nn50_count_o     <= '0;
        pnn50_percent_o  <= '0;
        interval_count_o <= '0;
      end else begin
        mean_rr_o        <= mean_r;
        sdnn_o           <= sdnn_r;
        rmssd_o          <= rmssd_r;
        nn50_count_o     <= nn_q;
        pnn50_percent_o  <= pnn_r;
        interval_count_o <= total_q;
      end
    end
  end

  assign status_o.last      = last_q;
  assign status_o.too_few   = too_few_c;
  assign status_o.neg       = neg_q;
  assign status_o.div_busy  = div_busy_q;
  assign status_o.sqrt_busy = sqrt_busy_q;

endmodule

// File: design/hrv_time_domain_stats.sv
// HRV time-domain statistics over one record of R-peak sample positions.
//
// Input channel: one item per R peak (peak_position_i, last_i), accepted when
// in_valid_i is high and in_stall_o is low. Output channel: one item per
// record, on the item marked last, accepted when out_valid_o is high and
// out_stall_i is low. Results are in sample periods, Q16.8 (pNN50 Q7.8).
// Each input item runs through three steps (capture, interval, accumulate),
// and a new item is taken only once the last one has finished them.
// A last item then runs the finishing sequence through one shared 32x32
// multiplier, a bit-serial divider (four divisions) and a serial square root
// (two roots); a negative variance skips one division and one root, and a
// record that is too short skips the whole sequence.
// The result sits in an output register; while the receiver stalls, new items
// of the next record are still accepted and accumulated, and only the next
// record's finishing step waits for that register to drain.
// Reset clears all accumulators and sets the NN50 threshold to 18 samples.
// Configuration: APB register 0 (address 0) holds the 10-bit threshold.
// Depends on hrv_tds_pkg, hrv_tds_ctrl and hrv_tds_dp.
module hrv_time_domain_stats #(
  parameter int unsigned MAX_INTERVALS  = hrv_tds_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned INTERVAL_WIDTH = hrv_tds_pkg::INTERVAL_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hrv_tds_pkg::ADDR_W-1:0]     paddr,
  input  logic [hrv_tds_pkg::DATA_W-1:0]     pwdata,
  output logic [hrv_tds_pkg::DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [31:0]                        peak_position_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hrv_tds_pkg::OUT_W-1:0]      mean_rr_o,
  output logic [hrv_tds_pkg::OUT_W-1:0]      sdnn_o,
  output logic [hrv_tds_pkg::OUT_W-1:0]      rmssd_o,
  output logic [hrv_tds_pkg::COUNT_W-1:0]    nn50_count_o,
  output logic [hrv_tds_pkg::PNN_W-1:0]      pnn50_percent_o,
  output logic [hrv_tds_pkg::COUNT_W-1:0]    interval_count_o,
  output logic                               too_few_o
);

  logic [hrv_tds_pkg::THR_W-1:0] thr_q;
  hrv_tds_pkg::cmd_t             cmd;
  hrv_tds_pkg::status_t          status;

  assign pready = 1'b1;
  assign prdata = (paddr == hrv_tds_pkg::ADDR_THR) ? hrv_tds_pkg::DATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= hrv_tds_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == hrv_tds_pkg::ADDR_THR)) begin
      thr_q <= pwdata[hrv_tds_pkg::THR_W-1:0];
    end
  end

  hrv_tds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hrv_tds_dp #(
    .MAX_INTERVALS  (MAX_INTERVALS),
    .INTERVAL_WIDTH (INTERVAL_WIDTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .thr_i            (thr_q),
    .peak_position_i  (peak_position_i),
    .last_i           (last_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .mean_rr_o        (mean_rr_o),
    .sdnn_o           (sdnn_o),
    .rmssd_o          (rmssd_o),
    .nn50_count_o     (nn50_count_o),
    .pnn50_percent_o  (pnn50_percent_o),
    .interval_count_o (interval_count_o),
    .too_few_o        (too_few_o)
  );

endmodule

// File: design/hrv_tds_checker.sv
// Port-level checks for the HRV statistics block, bound to the top level.
// Depends on hrv_time_domain_stats_defines.svh and hrv_tds_pkg.
`include "hrv_time_domain_stats_defines.svh"

module hrv_tds_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [hrv_tds_pkg::OUT_W-1:0]   mean_rr_o,
  input logic [hrv_tds_pkg::OUT_W-1:0]   sdnn_o,
  input logic [hrv_tds_pkg::OUT_W-1:0]   rmssd_o,
  input logic [hrv_tds_pkg::COUNT_W-1:0] nn50_count_o,
  input logic [hrv_tds_pkg::PNN_W-1:0]   pnn50_percent_o,
  input logic [hrv_tds_pkg::COUNT_W-1:0] interval_count_o,
  input logic                            too_few_o
);

  // A stalled result item stays and keeps its mean, SDNN, RMSSD, count and flag.
  `HRV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(mean_rr_o) && $stable(sdnn_o) && $stable(rmssd_o) && $stable(interval_count_o) && $stable(too_few_o), "stalled result item changed")

  // A short record reports nothing but the flag.
  `HRV_ASSERT_NOW(a_too_few_zero, out_valid_o && too_few_o, (mean_rr_o == '0) && (sdnn_o == '0) && (rmssd_o == '0) && (nn50_count_o == '0) && (pnn50_percent_o == '0) && (interval_count_o == '0), "short record result not cleared")

  // NN50 counts successive differences, of which there are n-1.
  `HRV_ASSERT_NOW(a_nn50_bound, out_valid_o && !too_few_o, (interval_count_o >= 16'd2) && (nn50_count_o < interval_count_o), "NN50 exceeds the number of differences")

  `HRV_ASSERT_NOW(a_pnn50_range, out_valid_o && !too_few_o, pnn50_percent_o <= 15'd25600, "pNN50 above one hundred percent")

endmodule

bind hrv_time_domain_stats hrv_tds_checker u_hrv_tds_checker (.*);

// File: tb/hrv_time_domain_stats_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the HRV time-domain statistics block.
// Drives R-peak records and APB threshold writes; needs hrv_tds_pkg and the RTL.

class hrv_record_scoreboard;
  typedef struct packed {
    logic [23:0] mean_rr;
    logic [23:0] sdnn;
    logic [23:0] rmssd;
    logic [15:0] nn50;
    logic [14:0] pnn50;
    logic [15:0] count;
    logic        too_few;
  } hrv_result_t;

  bit [9:0]    threshold;
  bit [31:0]   prev_peak;
  bit          have_peak;
  bit [15:0]   prev_iv;
  bit          have_iv;
  bit [15:0]   n_iv;
  bit [31:0]   sum_iv;
  bit [47:0]   sum_sq;
  bit [47:0]   sum_dsq;
  bit [15:0]   nn50_cnt;
  hrv_result_t pending_results[$];
  int          errors;

  function new();
    threshold = hrv_tds_pkg::THR_RESET;
    errors = 0;
    clear_record();
  endfunction

  function void clear_record();
    prev_peak = 0; have_peak = 0; prev_iv = 0; have_iv = 0; n_iv = 0;
    sum_iv = 0; sum_sq = 0; sum_dsq = 0; nn50_cnt = 0;
  endfunction

  static function bit [23:0] root_round(bit [63:0] x);
    bit [63:0] r;
    bit [63:0] bitv;
    bit [63:0] v;
    r = 0; bitv = 64'd1 << 62; v = x;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    if (x - r * r > r) r++;
    return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
  endfunction

  // Quotient saturated to 64 bits, as the divider does.
  static function bit [63:0] sat_quot(bit [127:0] num, bit [63:0] d);
    bit [127:0] q;
    q = num / d;
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function void note_peak(bit [31:0] peak, bit last);
    bit [16:0]   iv;
    bit [15:0]   d;
    bit [48:0]   t;
    bit [63:0]   n;
    bit [127:0]  a;
    bit [127:0]  b;
    bit [63:0]   q;
    hrv_result_t res;
    if (have_peak && n_iv < 16'hFFFF) begin
      iv = (peak >= prev_peak) ? ((peak - prev_peak > 32'hFFFF) ? 17'hFFFF : peak - prev_peak)
                               : 17'd0;
      n_iv++;
      t = {17'd0, sum_iv} + iv;
      sum_iv = (t > 49'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
      t = {1'b0, sum_sq} + iv * iv;
      sum_sq = t[48] ? 48'hFFFF_FFFF_FFFF : t[47:0];
      if (have_iv) begin
        d = (iv[15:0] >= prev_iv) ? iv[15:0] - prev_iv : prev_iv - iv[15:0];
        t = {1'b0, sum_dsq} + d * d;
        sum_dsq = t[48] ? 48'hFFFF_FFFF_FFFF : t[47:0];
        if (d > threshold && nn50_cnt != 16'hFFFF) nn50_cnt++;
      end
      prev_iv = iv[15:0];
      have_iv = 1;
    end
    prev_peak = peak;
    have_peak = 1;
    if (!last) return;
    res = '0;
    n = n_iv;
    if (n < 2) begin
      res.too_few = 1;
    end else begin
      q = ({32'd0, sum_iv} * 256 + n / 2) / n;
      res.mean_rr = (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
      a = n * sum_sq;
      b = sum_iv * sum_iv;
      if (a >= b) res.sdnn = root_round(sat_quot((a - b) << 16, n * (n - 1)));
      res.rmssd = root_round(sat_quot({80'd0, sum_dsq} << 16, n - 1));
      res.nn50 = nn50_cnt;
      q = ({48'd0, nn50_cnt} * 25600 + (n - 1) / 2) / (n - 1);
      res.pnn50 = (q > 64'h7FFF) ? 15'h7FFF : q[14:0];
      res.count = n_iv;
    end
    pending_results.push_back(res);
    clear_record();
  endfunction

  function void check_result(hrv_result_t got);
    hrv_result_t exp_r;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing expected");
      return;
    end
    exp_r = pending_results.pop_front();
    if (got.mean_rr !== exp_r.mean_rr) report_mismatch($sformatf("mean_rr %0d exp %0d", got.mean_rr, exp_r.mean_rr));
    if (got.sdnn !== exp_r.sdnn) report_mismatch($sformatf("sdnn %0d exp %0d", got.sdnn, exp_r.sdnn));
    if (got.rmssd !== exp_r.rmssd) report_mismatch($sformatf("rmssd %0d exp %0d", got.rmssd, exp_r.rmssd));
    if (got.nn50 !== exp_r.nn50) report_mismatch($sformatf("nn50 %0d exp %0d", got.nn50, exp_r.nn50));
    if (got.pnn50 !== exp_r.pnn50) report_mismatch($sformatf("pnn50 %0d exp %0d", got.pnn50, exp_r.pnn50));
    if (got.count !== exp_r.count) report_mismatch($sformatf("count %0d exp %0d", got.count, exp_r.count));
    if (got.too_few !== exp_r.too_few) report_mismatch($sformatf("too_few %0b exp %0b", got.too_few, exp_r.too_few));
  endfunction

  function void report_mismatch(string msg);
    errors++;
    if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction
endclass

module hrv_time_domain_stats_tb;

  localparam int LIMIT_CYCLES = 3_000_000;

  logic                                clk_i = 0;
  logic                                rst_ni = 0;
  logic                                psel = 0, penable = 0, pwrite = 0;
  logic [hrv_tds_pkg::ADDR_W-1:0]      paddr = '0;
  logic [hrv_tds_pkg::DATA_W-1:0]      pwdata = '0;
  logic [hrv_tds_pkg::DATA_W-1:0]      prdata;
  logic                                pready;
  logic                                in_valid_i = 0;
  logic                                in_stall_o;
  logic [31:0]                         peak_position_i = '0;
  logic                                last_i = 0;
  logic                                out_valid_o;
  logic                                out_stall_i = 0;
  logic [hrv_tds_pkg::OUT_W-1:0]       mean_rr_o, sdnn_o, rmssd_o;
  logic [hrv_tds_pkg::COUNT_W-1:0]     nn50_count_o, interval_count_o;
  logic [hrv_tds_pkg::PNN_W-1:0]       pnn50_percent_o;
  logic                                too_few_o;

  hrv_record_scoreboard hrv_sb = new();
  int  cycle_count = 0;
  bit  hold_long = 0;
  bit [31:0] peak_now;

  hrv_time_domain_stats u_dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      hrv_sb.check_result({mean_rr_o, sdnn_o, rmssd_o, nn50_count_o, pnn50_percent_o,
                           interval_count_o, too_few_o});
  end

  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1;
        for (k = 0; k < 3000; k++) @(posedge clk_i);
        hold_long = 0;
      end
      k = $urandom_range(0, 9);
      out_stall_i <= (k < 3) ? 1'b1 : 1'b0;
      @(posedge clk_i);
      if (k == 0) begin
        repeat ($urandom_range(5, 200)) @(posedge clk_i);
      end
    end
  end

  task automatic apb_write(input logic [hrv_tds_pkg::ADDR_W-1:0] addr,
                           input logic [31:0] data);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    hrv_sb.threshold = data[hrv_tds_pkg::THR_W-1:0];
  endtask

  task automatic send_peak(input logic [31:0] peak, input logic last, input bit gaps);
    int g;
    if (gaps) begin
      g = $urandom_range(0, 19);
      if (g < 4) begin
        in_valid_i <= 0;
        repeat ((g == 0) ? $urandom_range(20, 120) : $urandom_range(1, 3)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1; peak_position_i <= peak; last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hrv_sb.note_peak(peak, last);
  endtask

  task automatic drain_results();
    in_valid_i <= 0;
    while (hrv_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // Mostly plausible heartbeats; sometimes huge jumps, reversals or repeats.
  task automatic send_record(input int beats, input bit gaps);
    int i;
    int r;
    for (i = 0; i < beats; i++) begin
      r = $urandom_range(0, 99);
      if (i == 0) peak_now = $urandom;
      else if (r < 80) peak_now += $urandom_range(200, 500);
      else if (r < 88) peak_now += $urandom_range(0, 30);
      else if (r < 93) peak_now += $urandom;
      else if (r < 97) peak_now -= $urandom_range(0, 1000);
      else peak_now += 32'h10000 + $urandom_range(0, 5);
      send_peak(peak_now, i == beats - 1, gaps);
    end
  endtask

  initial begin
    int i;
    int items;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: lone peak, two peaks, full extremes, reversals, saturation.
    send_peak(32'hFFFF_FFFF, 1, 0);
    send_peak(32'd0, 0, 0);
    send_peak(32'd360, 1, 0);
    send_peak(32'd0, 0, 0);
    send_peak(32'd300, 0, 0);
    send_peak(32'd619, 0, 0);
    send_peak(32'd100, 0, 0);
    send_peak(32'hFFFF_FFFF, 0, 0);
    send_peak(32'hFFFF_FFFF, 0, 0);
    send_peak(32'hAAAA_AAAA, 0, 0);
    send_peak(32'h5555_5555, 1, 0);
    send_peak(32'd1000, 0, 0);
    send_peak(32'd1019, 0, 0);
    send_peak(32'd1038, 1, 0);
    drain_results();
    apb_write(hrv_tds_pkg::ADDR_THR, 32'd0);
    send_peak(32'd0, 0, 0);
    send_peak(32'd10, 0, 0);
    send_peak(32'd21, 0, 0);
    send_peak(32'd32, 1, 0);
    drain_results();
    apb_write(hrv_tds_pkg::ADDR_THR, 32'd1023);
    send_peak(32'd0, 0, 0);
    send_peak(32'd100, 0, 0);
    send_peak(32'd1200, 0, 0);
    send_peak(32'd1201, 1, 0);
    drain_results();
    apb_write(hrv_tds_pkg::ADDR_THR, 32'd1);
    send_record(6, 0);

    // Long receiver hold-off while records keep coming.
    hold_long = 1;
    send_record(40, 0);
    send_record(40, 0);
    drain_results();

    items = 0;
    while (items < 1000) begin
      if ($urandom_range(0, 7) == 0) begin
        drain_results();
        apb_write(hrv_tds_pkg::ADDR_THR, $urandom_range(1, 1023));
      end
      i = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      send_record(i, 1);
      items += i;
    end
    drain_results();
    apb_write(hrv_tds_pkg::ADDR_THR, 32'd1023);
    send_record(10, 1);
    drain_results();

    if (hrv_sb.errors == 0 && hrv_sb.pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
